[hw/rtl/sorted_list_table_macros.svh]
// Assertion macros shared by the sorted list table design.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLT_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sorted list table check failed");

// Next-cycle implication, checked outside reset.
`define SLT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sorted list table check failed");

`endif

[hw/rtl/slt_pkg.sv]
// Shared constants, operation codes and the cell control type.
package slt_pkg;

  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = 6;
  localparam int COUNT_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // Command broadcast to every cell for the item being accepted.
  typedef struct packed {
    logic put;     // insertion of some kind that fits
    logic front;   // prepend: every cell shifts up
    logic sorted;  // ordered insert: cells compare against the value
    logic take;    // valid remove: cells at and above the index shift down
  } ctrl_t;

endpackage

[hw/rtl/slt_if.sv]
// Request and response channel interfaces of the sorted list table.
interface slt_req_if;
  import slt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [IDX_W-1:0]          index;
  modport source (output valid, op, value, index, input ready);
  modport sink (input valid, op, value, index, output ready);
endinterface

interface slt_rsp_if;
  import slt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic                      index_ok;
  logic                      dropped;
  logic [COUNT_OUT_W-1:0]    entry_count;
  logic                      is_sorted;
  modport source (output valid, read_value, index_ok, dropped, entry_count, is_sorted,
                  input ready);
  modport sink (input valid, read_value, index_ok, dropped, entry_count, is_sorted,
                output ready);
endinterface

[hw/rtl/slt_cell.sv]
// One list cell: holds one entry and shifts with its neighbours.
module slt_cell #(
  parameter int VB  = 32,
  parameter int CW  = 7,
  parameter int POS = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  slt_pkg::ctrl_t           ctrl,
  input  logic signed [VB-1:0]     v,
  input  logic [CW-1:0]            count,
  input  logic [slt_pkg::IDX_W-1:0] idx,
  input  logic signed [VB-1:0]     left_entry,
  input  logic                     left_hit,
  input  logic signed [VB-1:0]     right_entry,
  output logic signed [VB-1:0]     entry,
  output logic                     hit,
  output logic                     ordered,
  output logic signed [VB-1:0]     rd_part
);
  import slt_pkg::*;

  localparam logic [CW-1:0]    POS_C  = CW'(POS);
  localparam bit               BEYOND = POS >= (1 << IDX_W);
  localparam logic [IDX_W-1:0] POS_I  = IDX_W'(POS);

  logic live;
  logic at_or_above;

  // A cell is live when it lies below the entry count.
  assign live = POS_C < count;

  // The insertion point is the first cell that is empty or holds a value not
  // below the new one; every cell from there upwards moves up by one.
  assign hit = left_hit | ctrl.front | !live | (ctrl.sorted & !(entry < v));

  assign at_or_above = BEYOND || (idx <= POS_I);
  assign ordered     = (POS == 0) || !live || (left_entry < entry);
  assign rd_part     = (!BEYOND && (idx == POS_I)) ? entry : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctrl.put && hit) begin
        entry <= left_hit ? left_entry : v;
      end else if (ctrl.take && at_or_above) begin
        entry <= right_entry;
      end
    end
  end

endmodule

[hw/rtl/sorted_list_table.sv]
// Sorted list table: a bounded list of signed values held in a chain of cells.
// Result path: two register stages, p and then the output register o, which holds a result until it is taken.
// Throughput: one request item per cycle while stage p is empty or can pass its item on;
// every cell compares and shifts at once, so the whole list is rewritten in the cycle the item is accepted.
// Reset (synchronous, active high) empties the list and drops any pending result;
// the entry words themselves are not cleared, as only entries below the count are read.
`include "sorted_list_table_macros.svh"

module sorted_list_table #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  slt_req_if.sink   req,
  slt_rsp_if.source rsp
);
  import slt_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // Cell chain: entries, insertion-point flags, order flags and read taps.
  logic signed [VALUE_BITS-1:0] ent     [CAPACITY];
  logic signed [VALUE_BITS-1:0] rd_part [CAPACITY];
  logic [CAPACITY-1:0]          hits;
  logic [CAPACITY-1:0]          ord;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Result pipeline: stage p holds the item just applied to the cells, stage o
  // is the output register that waits for the consumer.
  logic                         p_valid;
  logic signed [VALUE_BITS-1:0] p_rd;
  logic                         p_ok;
  logic                         p_drop;
  logic                         o_valid;
  logic signed [VALUE_W-1:0]    o_rd;
  logic                         o_ok;
  logic                         o_drop;
  logic [COUNT_OUT_W-1:0]       o_count;
  logic                         o_sorted;

  logic                         accept;
  logic                         o_free;
  logic                         p_move;
  logic                         full;
  logic                         put_op;
  logic                         idx_ok;
  ctrl_t                        ctrl;
  logic signed [VALUE_BITS-1:0] v;
  logic signed [VALUE_BITS-1:0] read_word;

  // The incoming value is taken as two's complement within the entry width.
  assign v = VALUE_BITS'(req.value);

  // Decode of the request. A full list refuses every kind of insertion, and an
  // index at or beyond the count makes a remove or read do nothing.
  always_comb begin
    full   = count == CW'(CAPACITY);
    put_op = req.op inside {OP_INSERT, OP_PREPEND, OP_APPEND};
    idx_ok = ((req.op == OP_REMOVE) || (req.op == OP_READ)) &&
             (CMPW'(req.index) < CMPW'(count));
    ctrl.put    = put_op && !full;
    ctrl.front  = req.op == OP_PREPEND;
    ctrl.sorted = req.op == OP_INSERT;
    ctrl.take   = (req.op == OP_REMOVE) && idx_ok;
  end

  // Handshake: stage p may be refilled whenever it can pass its item on, so a
  // result waiting in the output register stops new requests only while stage p
  // is occupied as well.
  assign o_free    = !o_valid || rsp.ready;
  assign p_move    = p_valid && o_free;
  assign req.ready = !rst && (!p_valid || o_free);
  assign accept    = req.valid && req.ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_entry;
    logic signed [VALUE_BITS-1:0] right_entry;
    logic                         left_hit;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_hit   = 1'b0;
    end else begin : g_inner
      assign left_entry = ent[i-1];
      assign left_hit   = hits[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = ent[i];
    end else begin : g_body
      assign right_entry = ent[i+1];
    end

    slt_cell #(
      .VB  (VALUE_BITS),
      .CW  (CW),
      .POS (i)
    ) u_cell (
      .clk         (clk),
      .en          (accept),
      .ctrl        (ctrl),
      .v           (v),
      .count       (count),
      .idx         (req.index),
      .left_entry  (left_entry),
      .left_hit    (left_hit),
      .right_entry (right_entry),
      .entry       (ent[i]),
      .hit         (hits[i]),
      .ordered     (ord[i]),
      .rd_part     (rd_part[i])
    );
  end

  // Only the cell whose position matches the index drives its tap, so the
  // read is an OR across the chain.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | rd_part[i];
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.put) begin
      count_next = count + CW'(1);
    end else if (ctrl.take) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers. The order flags of the cells describe the list as left
  // by the item in stage p, since no new item enters while p is held.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_rd   <= ((req.op == OP_READ) && idx_ok) ? read_word : '0;
      p_ok   <= idx_ok;
      p_drop <= put_op && full;
    end
    if (p_move) begin
      o_rd     <= VALUE_W'(p_rd);
      o_ok     <= p_ok;
      o_drop   <= p_drop;
      o_count  <= COUNT_OUT_W'(count);
      o_sorted <= &ord;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.read_value  = o_rd;
  assign rsp.index_ok    = o_ok;
  assign rsp.dropped     = o_drop;
  assign rsp.entry_count = o_count;
  assign rsp.is_sorted   = o_sorted;

  // A refused insertion can only have happened on a full list, which it left full.
  `SLT_ASSERT_NOW(a_drop_full, clk, rst, p_valid && p_drop, count == CW'(CAPACITY))
  // An accepted insertion that fits grows the list by exactly one entry.
  `SLT_ASSERT_NEXT(a_put_grows, clk, rst, accept && ctrl.put, count == $past(count) + CW'(1))
  // Requests that neither insert nor remove leave the count alone.
  `SLT_ASSERT_NEXT(a_count_hold, clk, rst, accept && !ctrl.put && !ctrl.take, $stable(count))

endmodule
